// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When ante holds, cons must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and the character map of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [5:0] SEXTET_62 = 6'd62;
  localparam logic [5:0] SEXTET_63 = 6'd63;

  // One finished group handed from the decode stage to the byte serializer.
  // data[0] is sent first (the high byte of the 24-bit word).
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            msg_end;
  } group_t;

  // Maps one character to its sextet. Unknown codes, '=' included, give 0.
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    case (c) inside
      [8'h41:8'h5A]:        v = c - 8'h41;
      [8'h61:8'h7A]:        v = c - 8'h47;
      [8'h30:8'h39]:        v = c + 8'h04;
      8'h2B, 8'h2D, 8'h2E:  v = {2'b00, SEXTET_62};
      8'h2C, 8'h2F, 8'h5F:  v = {2'b00, SEXTET_63};
      default:              v = 8'h00;
    endcase
    return v[5:0];
  endfunction

endpackage

// File: sv/b64sd_decode.sv
// ----------------------------------------------------------------------------
// b64sd_decode
// Group state, sextet packing and length limiting for one character per beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64sd_decode #(
  parameter int LEN_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           enc_char,
  input  logic                 first_of_message,
  input  logic [LEN_BITS-1:0]  decoded_len,
  output logic                 completes,
  output logic                 grp_load,
  output b64sd_pkg::group_t    grp
);

  logic [17:0]         sextet_accum;
  logic [1:0]          group_pos;
  logic [LEN_BITS-1:0] bytes_done;

  logic [17:0]         acc_eff;
  logic [1:0]          gp_eff;
  logic [LEN_BITS-1:0] bd_eff;
  logic [5:0]          sx;
  logic                skip;
  logic [23:0]         word;
  logic [LEN_BITS-1:0] rem;
  logic [1:0]          n;

  // A first-of-message beat sees the cleared state.
  assign acc_eff = first_of_message ? 18'd0 : sextet_accum;
  assign gp_eff  = first_of_message ? 2'd0 : group_pos;
  assign bd_eff  = first_of_message ? '0 : bytes_done;

  assign sx        = b64sd_pkg::sextet_of(enc_char);
  assign skip      = (gp_eff == 2'd0) &&
                     (enc_char == b64sd_pkg::CHAR_CR || enc_char == b64sd_pkg::CHAR_LF);
  assign completes = (gp_eff == 2'd3);
  assign word      = {acc_eff, sx};

  always_comb begin
    rem = (bd_eff < decoded_len) ? (decoded_len - bd_eff) : '0;
    if (rem >= LEN_BITS'(3)) begin
      n = 2'd3;
    end else begin
      n = rem[1:0];
    end
  end

  assign grp_load     = in_fire && completes;
  assign grp.data[0]  = word[23:16];
  assign grp.data[1]  = word[15:8];
  assign grp.data[2]  = word[7:0];
  assign grp.cnt      = n;
  assign grp.msg_end  = (n != 2'd0) && (rem <= LEN_BITS'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_accum <= '0;
      group_pos    <= '0;
      bytes_done   <= '0;
    end else if (in_fire) begin
      if (skip) begin
        sextet_accum <= acc_eff;
        group_pos    <= gp_eff;
        bytes_done   <= bd_eff;
      end else if (!completes) begin
        sextet_accum <= {acc_eff[11:0], sx};
        group_pos    <= gp_eff + 2'd1;
        bytes_done   <= bd_eff;
      end else begin
        sextet_accum <= '0;
        group_pos    <= '0;
        bytes_done   <= bd_eff + LEN_BITS'(n);
      end
    end
  end

  `ASSERT_NEXT(a_group_clears, clk, rst, grp_load, group_pos == 2'd0 && sextet_accum == 18'd0)
  `ASSERT_NEXT(a_skip_holds_pos, clk, rst, in_fire && skip, group_pos == 2'd0)
  `ASSERT_ALWAYS(a_msg_end_has_bytes, clk, rst, !(grp_load && grp.msg_end && grp.cnt == 2'd0))

endmodule

// File: sv/b64sd_serial.sv
// ----------------------------------------------------------------------------
// b64sd_serial
// Holds one decoded group and sends its bytes out one beat at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64sd_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              grp_load,
  input  b64sd_pkg::group_t grp,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              last_of_group,
  output logic              last_of_message
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [1:0] cnt;
  logic       msg_end;
  logic       out_fire;

  assign out_valid       = (cnt != 2'd0);
  assign out_fire        = out_valid && !out_stall;
  assign out_byte        = b0;
  assign last_of_group   = (cnt == 2'd1);
  assign last_of_message = (cnt == 2'd1) && msg_end;

  // Free for a new group once the last held byte leaves in this cycle.
  assign busy = (cnt > 2'd1) || ((cnt == 2'd1) && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (grp_load) begin
      cnt <= grp.cnt;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      b0      <= grp.data[0];
      b1      <= grp.data[1];
      b2      <= grp.data[2];
      msg_end <= grp.msg_end;
    end else if (out_fire) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

  `ASSERT_ALWAYS(a_no_overrun, clk, rst, !(grp_load && busy))
  `ASSERT_NEXT(a_drain_step, clk, rst, out_fire && !grp_load, cnt == $past(cnt) - 2'd1)
  `ASSERT_NEXT(a_load_count, clk, rst, grp_load, cnt == $past(grp.cnt))

endmodule

// File: sv/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one encoded character in, up to three bytes out.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | enc_char, first_of_message
//  out      | out_valid / out_stall| out_byte, last_of_group, last_of_message
//  config   | cfg_wr_en            | cfg_wr_data (decoded length)
//
// A character beat is taken every cycle unless in_stall holds it; the group
// state and, for a finished group, the output buffer update in the same cycle.
// A fourth character of a group waits only while the buffer still holds more
// than one byte, or its last byte is stalled; three bytes per four characters
// keep the average at one character per cycle while the output is not stalled.
// Synchronous reset clears the group state, byte count, buffer and length.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
  parameter int LEN_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          enc_char,
  input  logic                first_of_message,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_group,
  output logic                last_of_message,
  input  logic                cfg_wr_en,
  input  logic [LEN_BITS-1:0] cfg_wr_data
);

  logic [LEN_BITS-1:0] decoded_len;
  logic                in_fire;
  logic                completes;
  logic                grp_load;
  logic                busy;
  b64sd_pkg::group_t   grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoded_len <= '0;
    end else if (cfg_wr_en) begin
      decoded_len <= cfg_wr_data;
    end
  end

  // Only a beat that finishes a group needs room in the output buffer.
  assign in_stall = busy && completes;
  assign in_fire  = in_valid && !in_stall;

  b64sd_decode #(
    .LEN_BITS(LEN_BITS)
  ) u_decode (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (in_fire),
    .enc_char         (enc_char),
    .first_of_message (first_of_message),
    .decoded_len      (decoded_len),
    .completes        (completes),
    .grp_load         (grp_load),
    .grp              (grp)
  );

  b64sd_serial u_serial (
    .clk             (clk),
    .rst             (rst),
    .grp_load        (grp_load),
    .grp             (grp),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .last_of_group   (last_of_group),
    .last_of_message (last_of_message)
  );

endmodule

// File: tb/base64_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the base64 stream decoder. A directed table covers
// the sextet map extremes, CR/LF handling, a zero length, a length reached
// mid-group and a lowered length. Random messages follow under several
// decoded lengths. Every output beat is checked against typed row values or an
// internal decoder model, with random valid and stall gaps on both channels.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

  localparam int LEN_W = 24;
  localparam int ITEMS = 200;
  localparam int DRAIN = 6;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic [7:0] data;
    logic       grp_end;
    logic       msg_end;
  } dec_byte_t;

  // One directed row: optional length write before the char, and an optional
  // typed expectation (bytes high first, lom bit 2 for the first byte).
  typedef struct packed {
    logic [7:0]       ch;
    logic             fst;
    logic             wr;
    logic [LEN_W-1:0] len;
    logic             typed;
    logic [1:0]       n;
    logic [23:0]      bytes;
    logic [2:0]       lom;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       enc_char;
  logic             first_of_message;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte;
  logic             last_of_group;
  logic             last_of_message;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  // Decoder model state.
  logic [17:0]      acc;
  logic [1:0]       grp_pos;
  logic [LEN_W-1:0] done_cnt;
  logic [LEN_W-1:0] len_reg;
  dec_byte_t        fresh [3];

  dec_byte_t        pending_bytes [$];
  dir_row_t         dir_tab [25];
  int               mismatches;
  bit               calm;
  int               hold_req;

  base64_stream_decoder #(
    .LEN_BITS(LEN_W)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .enc_char         (enc_char),
    .first_of_message (first_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .last_of_group    (last_of_group),
    .last_of_message  (last_of_message),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [5:0] char_to_sextet(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return 6'(ch - "A");
    if (ch >= "a" && ch <= "z") return 6'(ch - "a" + 26);
    if (ch >= "0" && ch <= "9") return 6'(ch - "0" + 52);
    if (ch == "+" || ch == "-" || ch == ".") return b64sd_pkg::SEXTET_62;
    if (ch == "," || ch == "/" || ch == "_") return b64sd_pkg::SEXTET_63;
    return 6'd0;
  endfunction

  // Advances the model by one character and leaves its bytes in fresh[].
  function automatic int decode_char(input logic [7:0] ch, input logic fst,
                                     output bit ignored);
    logic [23:0] word;
    int n;
    ignored = 1'b0;
    n = 0;
    if (fst) begin
      grp_pos = '0;
      acc = '0;
      done_cnt = '0;
    end
    if (grp_pos == 2'd0 && (ch == b64sd_pkg::CHAR_CR || ch == b64sd_pkg::CHAR_LF)) begin
      ignored = 1'b1;
      return 0;
    end
    if (grp_pos != 2'd3) begin
      acc = {acc[11:0], char_to_sextet(ch)};
      grp_pos = grp_pos + 2'd1;
      return 0;
    end
    word = {acc, char_to_sextet(ch)};
    grp_pos = '0;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      if (done_cnt < len_reg) begin
        done_cnt = done_cnt + 1'b1;
        fresh[n].data = word[23-8*k -: 8];
        fresh[n].grp_end = 1'b0;
        fresh[n].msg_end = (done_cnt == len_reg);
        n++;
      end
    end
    if (n > 0) fresh[n-1].grp_end = 1'b1;
    return n;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 68);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    case (r)
      62: return "+";
      63: return "-";
      64: return ".";
      65: return ",";
      66: return "/";
      67: return "_";
      default: return "=";
    endcase
  endfunction

  // Offers one character beat, waits for it to be taken, then records what
  // it should produce: typed values for a typed table row, the model otherwise.
  task automatic push_char(input logic [7:0] ch, input logic fst, input bit typed,
                           input int row, output bit ignored);
    int n;
    dec_byte_t b;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    enc_char = ch;
    first_of_message = fst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = decode_char(ch, fst, ignored);
    if (typed) begin
      for (int k = 0; k < dir_tab[row].n; k++) begin
        b.data = dir_tab[row].bytes[23-8*k -: 8];
        b.grp_end = (k == dir_tab[row].n - 1);
        b.msg_end = dir_tab[row].lom[2-k];
        pending_bytes.push_back(b);
      end
    end else begin
      for (int k = 0; k < n; k++) pending_bytes.push_back(fresh[k]);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    len_reg = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    int hold_ack;
    int hold_left;
    hold_ack = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !calm && ($urandom_range(99) < 26);
      end
    end
  end

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: nothing expected, actual %h", out_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, out_byte);
          mismatches++;
        end
        if (last_of_group !== want.grp_end) begin
          $error("last_of_group: expected %b, actual %b", want.grp_end, last_of_group);
          mismatches++;
        end
        if (last_of_message !== want.msg_end) begin
          $error("last_of_message: expected %b, actual %b", want.msg_end,
                 last_of_message);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int counted;
    int phase;
    int ngroups;
    int nchars;
    logic [LEN_W-1:0] new_len;
    logic [7:0] ch;
    logic fst;
    bit ign;

    rst = 1'b1;
    in_valid = 1'b0;
    enc_char = '0;
    first_of_message = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    acc = '0;
    grp_pos = '0;
    done_cnt = '0;
    len_reg = '0;
    mismatches = 0;
    calm = 1'b0;
    hold_req = 0;
    counted = 0;

    dir_tab = '{
      // Full length: all ones, then CR skipped at the boundary.
      '{"/",    1'b1, 1'b1, 24'hFFFFFF, 1'b1, 2'd0, 24'h000000, 3'b000},
      '{"/",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"/",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"/",    1'b0, 1'b0, 24'h0,      1'b1, 2'd3, 24'hFFFFFF, 3'b000},
      '{b64sd_pkg::CHAR_CR, 1'b0, 1'b0, 24'h0, 1'b1, 2'd0, 24'h000000, 3'b000},
      // LF and CR inside a group decode as zero, as does the pad char.
      '{"A",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{b64sd_pkg::CHAR_LF, 1'b0, 1'b0, 24'h0, 1'b1, 2'd0, 24'h000000, 3'b000},
      '{b64sd_pkg::CHAR_CR, 1'b0, 1'b0, 24'h0, 1'b1, 2'd0, 24'h000000, 3'b000},
      '{"=",    1'b0, 1'b0, 24'h0,      1'b1, 2'd3, 24'h000000, 3'b000},
      // Zero length: nothing comes out.
      '{8'hFF,  1'b1, 1'b1, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{8'h00,  1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"_",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{",",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      // Length four: the second group is cut after its first byte.
      '{"Q",    1'b1, 1'b1, 24'd4,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"U",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"J",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"D",    1'b0, 1'b0, 24'h0,      1'b1, 2'd3, 24'h414243, 3'b000},
      '{"R",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"E",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"V",    1'b0, 1'b0, 24'h0,      1'b1, 2'd0, 24'h000000, 3'b000},
      '{"G",    1'b0, 1'b0, 24'h0,      1'b1, 2'd1, 24'h440000, 3'b100},
      // Length lowered below the bytes already sent.
      '{"+",    1'b0, 1'b1, 24'd2,      1'b0, 2'd0, 24'h000000, 3'b000},
      '{"-",    1'b0, 1'b0, 24'h0,      1'b0, 2'd0, 24'h000000, 3'b000},
      '{".",    1'b0, 1'b0, 24'h0,      1'b0, 2'd0, 24'h000000, 3'b000},
      '{"z",    1'b0, 1'b0, 24'h0,      1'b0, 2'd0, 24'h000000, 3'b000}
    };

    repeat (2) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 25; i++) begin
      if (dir_tab[i].wr) write_len(dir_tab[i].len);
      push_char(dir_tab[i].ch, dir_tab[i].fst, dir_tab[i].typed, i, ign);
    end

    // Random messages, one decoded length each.
    phase = 0;
    while (counted < ITEMS) begin
      ngroups = (phase == 1) ? 12 : $urandom_range(1, 8);
      case ($urandom_range(9))
        0: new_len = '0;
        1: new_len = '1;
        2: new_len = LEN_W'($urandom);
        default: new_len = LEN_W'($urandom_range(0, 3 * ngroups + 2));
      endcase
      // Every group of the held-off message must put bytes in the buffer.
      if (phase == 1) new_len = '1;
      write_len(new_len);
      calm = (phase == 2);
      // The output holds off long enough for the decoder to back up.
      if (phase == 1) hold_req++;
      for (int g = 0; g < ngroups; g++) begin
        if (phase == 4 && g == ngroups / 2) wait_idle();
        if (g > 0 && $urandom_range(99) < 20)
          push_char($urandom_range(1) ? b64sd_pkg::CHAR_CR : b64sd_pkg::CHAR_LF,
                    1'b0, 1'b0, 0, ign);
        nchars = (g == ngroups - 1 && $urandom_range(9) == 0) ? $urandom_range(1, 3) : 4;
        for (int c = 0; c < nchars; c++) begin
          fst = (g == 0 && c == 0) || ($urandom_range(99) < 3);
          ch = ($urandom_range(99) < 85) ? pick_char() : 8'($urandom);
          push_char(ch, fst, 1'b0, 0, ign);
          if (!ign) counted++;
        end
      end
      phase++;
    end
    calm = 1'b0;

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: base64_stream_decoder.f
+incdir+sv
sv/b64sd_pkg.sv
sv/b64sd_decode.sv
sv/b64sd_serial.sv
sv/base64_stream_decoder.sv
tb/base64_stream_decoder_tb.sv
